[rtl/uts_pkg.sv]
// uts_pkg: shared types and constants of the utf-8 text sanitizer
// no dependencies; compiled before every other file of the block

package uts_pkg;

  localparam int unsigned MaxRun = 5;
  localparam int unsigned RunCountW = $clog2(MaxRun + 1);
  localparam int unsigned RunIdxW = $clog2(MaxRun);
  localparam int unsigned HeldDepth = 3;

  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDigitZero = 8'h30;
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChAsciiEnd = 8'h80;

  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;
  localparam logic [7:0] LeadSurr = 8'hED;
  localparam logic [7:0] Cont3Min = 8'hA0;
  localparam logic [7:0] Cont4Min = 8'h90;

  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] Seq2 = 3'd2;
  localparam logic [2:0] Seq3 = 3'd3;
  localparam logic [2:0] Seq4 = 3'd4;

  typedef struct packed {
    logic [MaxRun-1:0][7:0] data;
    logic [RunCountW-1:0]   count;
  } run_t;

  typedef struct packed {
    logic       hold_we;
    logic [1:0] hold_idx;
    logic [1:0] held_count;
    logic [2:0] seq_len;
  } next_t;

endpackage

[rtl/uts_if.sv]
// uts_in_if / uts_out_if: valid-ready channels of the utf-8 text sanitizer
// depends on nothing; raw text beats in, sanitized text beats out

interface uts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface uts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_last;

  modport source (output valid, output out_byte, output run_last, output text_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input text_last,
                output ready);
endinterface

[rtl/uts_step.sv]
// uts_step: combinational decode of one input byte against the pending sequence
// depends on uts_pkg; yields the run of result bytes and the next sequence state

module uts_step (
  input  logic [7:0]       in_byte,
  input  logic             end_of_text,
  input  logic [7:0]       held_bytes [uts_pkg::HeldDepth],
  input  logic [1:0]       held_count,
  input  logic [2:0]       seq_len,
  output uts_pkg::run_t    run,
  output uts_pkg::next_t   nxt
);
  import uts_pkg::*;

  logic                 pending;
  logic                 cont_ok;
  logic                 consumed;
  logic                 complete;
  logic [2:0]           held_plus;
  logic [2:0]           lead_len;
  logic [7:0]           f0;
  logic [7:0]           f1;
  logic [1:0]           fn;
  logic                 f_hold;
  logic [2:0]           q;
  logic [7:0]           held_pad [MaxRun];

  assign pending = (seq_len != SeqNone) && (held_count != 2'd0);
  assign held_plus = {1'b0, held_count} + 3'd1;

  always_comb begin
    cont_ok = (in_byte[7:6] == 2'b10);
    if (held_count == 2'd1) begin
      if ((held_bytes[0] == Lead3Lo && in_byte < Cont3Min) ||
          (held_bytes[0] == LeadSurr && in_byte >= Cont3Min) ||
          (held_bytes[0] == Lead4Lo && in_byte < Cont4Min) ||
          (held_bytes[0] == Lead4Hi && in_byte >= Cont4Min)) begin
        cont_ok = 1'b0;
      end
    end
  end

  assign consumed = pending && cont_ok;
  assign complete = consumed && (held_plus >= seq_len);

  always_comb begin
    if (in_byte >= Lead2Lo && in_byte <= Lead2Hi) begin
      lead_len = Seq2;
    end else if (in_byte >= Lead3Lo && in_byte <= Lead3Hi) begin
      lead_len = Seq3;
    end else if (in_byte >= Lead4Lo && in_byte <= Lead4Hi) begin
      lead_len = Seq4;
    end else begin
      lead_len = SeqNone;
    end
  end

  // byte taken as if no sequence were pending
  always_comb begin
    f0 = ChQuestion;
    f1 = ChQuestion;
    fn = 2'd1;
    f_hold = 1'b0;
    if (in_byte == ChNul) begin
      f0 = ChBackslash;
      f1 = ChDigitZero;
      fn = 2'd2;
    end else if (in_byte < ChSpace) begin
      if (in_byte == ChTab || in_byte == ChLf || in_byte == ChCr) begin
        f0 = in_byte;
      end
    end else if (in_byte < ChAsciiEnd) begin
      f0 = in_byte;
    end else if (lead_len != SeqNone && !end_of_text) begin
      fn = 2'd0;
      f_hold = 1'b1;
    end
  end

  assign q = (pending && !consumed) ? {1'b0, held_count} : 3'd0;

  always_comb begin
    for (int i = 0; i < MaxRun; i++) begin
      held_pad[i] = in_byte;
    end
    for (int i = 0; i < HeldDepth; i++) begin
      if (3'(i) < {1'b0, held_count}) begin
        held_pad[i] = held_bytes[i];
      end
    end
  end

  always_comb begin
    run.data = '0;
    run.count = '0;
    nxt.hold_we = 1'b0;
    nxt.hold_idx = held_count;
    nxt.held_count = 2'd0;
    nxt.seq_len = SeqNone;
    if (complete) begin
      for (int i = 0; i < MaxRun; i++) begin
        run.data[i] = held_pad[i];
      end
      run.count = RunCountW'(held_plus);
    end else if (consumed) begin
      nxt.hold_we = 1'b1;
      if (end_of_text) begin
        for (int i = 0; i < MaxRun; i++) begin
          run.data[i] = ChQuestion;
        end
        run.count = RunCountW'(held_plus);
      end else begin
        nxt.held_count = held_plus[1:0];
        nxt.seq_len = seq_len;
      end
    end else begin
      for (int i = 0; i < MaxRun; i++) begin
        if (3'(i) < q) begin
          run.data[i] = ChQuestion;
        end else if (3'(i) == q) begin
          run.data[i] = f0;
        end else begin
          run.data[i] = f1;
        end
      end
      run.count = RunCountW'(q + {1'b0, fn});
      if (f_hold) begin
        nxt.hold_we = 1'b1;
        nxt.hold_idx = 2'd0;
        nxt.held_count = 2'd1;
        nxt.seq_len = lead_len;
      end
    end
  end

endmodule

[rtl/utf8_text_sanitizer.sv]
// utf8_text_sanitizer: top level, sequence state and output run buffer
// depends on uts_pkg, uts_if (uts_in_if, uts_out_if) and uts_step

// Takes one raw byte per beat on raw and gives sanitized bytes on clean. Each
// input byte is decoded in the cycle it is accepted and yields a run of zero to
// five output bytes, held in a run buffer and sent one per cycle while clean is
// ready; a byte that only extends a pending multibyte sequence gives no output. A
// new byte is taken in the cycle the last byte of the previous run leaves, so one
// byte per cycle is sustained when every run has one byte and clean stays ready.
// The first byte of a run is offered in the cycle after its input beat is taken.
// run_last marks the final byte of each run and text_last the final byte of the
// text.

module utf8_text_sanitizer (
  input logic    clk,
  input logic    rst,
  uts_in_if.sink     raw,
  uts_out_if.source  clean
);
  import uts_pkg::*;

  logic [7:0]              held_bytes [HeldDepth];
  logic [1:0]              held_count;
  logic [2:0]              seq_len;
  logic [MaxRun-1:0][7:0]  run_data;
  logic [RunCountW-1:0]    run_count;
  logic [RunIdxW-1:0]      run_idx;
  logic                    run_end;
  logic                    run_valid;
  logic                    at_last;
  logic                    last_beat;
  logic                    take;
  run_t                    step_run;
  next_t                   step_nxt;

  uts_step u_step (
    .in_byte     (raw.in_byte),
    .end_of_text (raw.end_of_text),
    .held_bytes  (held_bytes),
    .held_count  (held_count),
    .seq_len     (seq_len),
    .run         (step_run),
    .nxt         (step_nxt)
  );

  assign at_last = (RunCountW'(run_idx) == (run_count - RunCountW'(1)));
  assign last_beat = run_valid && clean.ready && at_last;
  assign raw.ready = !run_valid || last_beat;
  assign take = raw.valid && raw.ready;

  assign clean.valid = run_valid;
  assign clean.out_byte = run_data[run_idx];
  assign clean.run_last = at_last;
  assign clean.text_last = at_last && run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_len <= SeqNone;
    end else if (take) begin
      held_count <= step_nxt.held_count;
      seq_len <= step_nxt.seq_len;
    end
  end

  always_ff @(posedge clk) begin
    if (take && step_nxt.hold_we) begin
      held_bytes[step_nxt.hold_idx] <= raw.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_idx <= '0;
    end else if (take) begin
      run_valid <= (step_run.count != '0);
      run_idx <= '0;
    end else if (last_beat) begin
      run_valid <= 1'b0;
      run_idx <= '0;
    end else if (run_valid && clean.ready) begin
      run_idx <= run_idx + RunIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run_data <= step_run.data;
      run_count <= step_run.count;
      run_end <= raw.end_of_text;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (RunCountW'(run_idx) < run_count))
    else $error("run index past run length");

  a_state_pair: assert property (@(posedge clk) disable iff (rst)
    (held_count != 2'd0) == (seq_len != SeqNone))
    else $error("held count and sequence length disagree");

  a_held_short: assert property (@(posedge clk) disable iff (rst)
    (seq_len != SeqNone) |-> ({1'b0, held_count} < seq_len))
    else $error("pending sequence already complete");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (take && raw.end_of_text) |=> (held_count == 2'd0))
    else $error("sequence still pending after end of text");
`endif

endmodule
